// ===== rtl/khash_pkg.sv =====
package khash_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned CFG_W     = 30;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned SUM_W     = 31;
   localparam int unsigned TERM_W    = 38;
   localparam int unsigned ACC_W     = 40;
   localparam int unsigned PROD_W    = 60;
   localparam int unsigned STEP_W    = 6;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [KIND_W-1:0] KIND_SCALAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 1'b1;

   localparam logic [CFG_W-1:0] BASE_RESET    = 30'd31;
   localparam logic [CFG_W-1:0] MODULUS_RESET = 30'd1000000009;

   localparam logic [CHAR_W+1:0] CHAR_OFFSET = 10'd96;

   localparam logic [STEP_W-1:0] SUM_STEPS = 6'd40;
   localparam logic [STEP_W-1:0] POW_STEPS = 6'd60;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TERM_MUL,
      ST_TERM_ADD,
      ST_SUM_START,
      ST_SUM_RED,
      ST_POW_MUL,
      ST_POW_START,
      ST_POW_RED,
      ST_EMIT
   } khash_state_type;

   typedef struct packed {
      logic load_item;
      logic term_mul;
      logic term_add;
      logic sum_start;
      logic sum_write;
      logic pow_mul;
      logic pow_start;
      logic pow_write;
      logic emit;
   } khash_cmd_type;

   typedef struct packed {
      logic is_last;
      logic red_busy;
      logic out_free;
   } khash_status_type;

endpackage

// ===== rtl/khash_req_if.sv =====
interface khash_req_if
   import khash_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] key_kind;
   logic [WORD_W-1:0] key_value;
   logic              last;

   modport source (output valid, output key_kind, output key_value, output last,
                   input ready);
   modport sink   (input valid, input key_kind, input key_value, input last,
                   output ready);
endinterface

// ===== rtl/khash_rsp_if.sv =====
interface khash_rsp_if
   import khash_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] hash_word;
   logic              unhashable;

   modport source (output valid, output hash_word, output unhashable, input ready);
   modport sink   (input valid, input hash_word, input unhashable, output ready);
endinterface

// ===== rtl/khash_reducer.sv =====
module khash_reducer
   import khash_pkg::*;
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [STEP_W-1:0] steps,
   input  logic [CFG_W-1:0]  modulus,
   output logic              busy,
   output logic [CFG_W-1:0]  remainder
   );

   logic [STEP_W-1:0] count_ff, count_in;
   logic [PROD_W-1:0] shift_ff, shift_in;
   logic [CFG_W-1:0]  rem_ff, rem_in;
   logic [CFG_W:0]    trial;
   logic [CFG_W:0]    trial_sub;

   // restoring step: bring in the next dividend bit, subtract when it fits
   assign trial     = {rem_ff, shift_ff[PROD_W-1]};
   assign trial_sub = trial - {1'b0, modulus};

   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = steps;
         shift_in = dividend;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         shift_in = {shift_ff[PROD_W-2:0], 1'b0};
         rem_in   = (trial >= {1'b0, modulus}) ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign busy      = (count_ff != '0);
   assign remainder = rem_ff;

endmodule

// ===== rtl/khash_dpath.sv =====
module khash_dpath
   import khash_pkg::*;
   (
   input  logic                 clock,
   input  logic                 reset,
   input  khash_cmd_type        cmd,
   output khash_status_type     status,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic [KIND_W-1:0]    key_kind,
   input  logic [WORD_W-1:0]    key_value,
   input  logic                 key_last,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [WORD_W-1:0]    rsp_hash_word,
   output logic                 rsp_unhashable
   );

   logic [CFG_W-1:0]  base_ff, base_in;
   logic [CFG_W-1:0]  modulus_ff, modulus_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic              last_ff, last_in;
   logic              neg_ff, neg_in;
   logic [CHAR_W-1:0] mag_ff, mag_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CFG_W-1:0]  power_ff, power_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic              unh_ff, unh_in;

   logic [CHAR_W+1:0] char_term;
   logic [CHAR_W+1:0] char_mag;
   logic [CFG_W-1:0]  mul_b;
   logic [PROD_W-1:0] product;
   logic [ACC_W-1:0]  sum_wide;
   logic [ACC_W-1:0]  prod_wide;
   logic [ACC_W-1:0]  acc_mag;
   logic [CFG_W-1:0]  modulus_eff;
   logic              red_start;
   logic [PROD_W-1:0] red_dividend;
   logic [STEP_W-1:0] red_steps;
   logic              red_busy;
   logic [CFG_W-1:0]  red_rem;
   logic [SUM_W-1:0]  rem_wide;
   logic              out_free;

   // signed character minus offset, kept as sign and magnitude
   assign char_term = {{2{key_value[CHAR_W-1]}}, key_value[CHAR_W-1:0]} - CHAR_OFFSET;
   assign char_mag  = char_term[CHAR_W+1] ? (~char_term + 1'b1) : char_term;

   // one shared multiplier for the term and the power update
   assign mul_b   = cmd.term_mul ? CFG_W'(mag_ff) : base_ff;
   assign product = PROD_W'(power_ff) * PROD_W'(mul_b);

   assign sum_wide  = {{(ACC_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
   assign prod_wide = ACC_W'(prod_ff[TERM_W-1:0]);
   assign acc_mag   = acc_ff[ACC_W-1] ? (~acc_ff + 1'b1) : acc_ff;

   assign modulus_eff = (modulus_ff == '0) ? CFG_W'(1) : modulus_ff;

   assign red_start    = cmd.sum_start | cmd.pow_start;
   assign red_dividend = cmd.sum_start ? {acc_mag, {(PROD_W-ACC_W){1'b0}}} : prod_ff;
   assign red_steps    = cmd.sum_start ? SUM_STEPS : POW_STEPS;

   assign rem_wide = {1'b0, red_rem};
   assign out_free = ~rsp_valid_ff | rsp_ready;

   khash_reducer u_reducer (
      .clock     (clock),
      .reset     (reset),
      .start     (red_start),
      .dividend  (red_dividend),
      .steps     (red_steps),
      .modulus   (modulus_eff),
      .busy      (red_busy),
      .remainder (red_rem)
   );

   always_comb begin
      base_in      = base_ff;
      modulus_in   = modulus_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      sum_in       = sum_ff;
      power_in     = power_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      hash_in      = hash_ff;
      unh_in       = unh_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_BASE:    base_in    = csr_wdata;
            CSR_MODULUS: modulus_in = csr_wdata;
            default:     ;
         endcase
      end

      if (cmd.load_item) begin
         kind_in  = key_kind;
         value_in = key_value;
         last_in  = key_last;
         neg_in   = char_term[CHAR_W+1];
         mag_in   = char_mag[CHAR_W-1:0];
         // any other kind drops a partial string
         if (key_kind != KIND_CHAR) begin
            sum_in   = '0;
            power_in = CFG_W'(1);
         end
      end

      if (cmd.term_mul || cmd.pow_mul) begin
         prod_in = product;
      end

      if (cmd.term_add) begin
         acc_in = sum_wide + (neg_ff ? (~prod_wide + 1'b1) : prod_wide);
      end

      if (cmd.sum_write) begin
         sum_in = acc_ff[ACC_W-1] ? (~rem_wide + 1'b1) : rem_wide;
      end

      if (cmd.pow_write) begin
         power_in = red_rem;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (kind_ff == KIND_SCALAR) begin
            hash_in = value_ff;
            unh_in  = 1'b0;
         end else if (kind_ff == KIND_CHAR) begin
            hash_in  = {sum_ff[SUM_W-1], sum_ff};
            unh_in   = 1'b0;
            sum_in   = '0;
            power_in = CFG_W'(1);
         end else begin
            hash_in = '0;
            unh_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         modulus_ff   <= MODULUS_RESET;
         sum_ff       <= '0;
         power_ff     <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         modulus_ff   <= modulus_in;
         sum_ff       <= sum_in;
         power_ff     <= power_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      hash_ff  <= hash_in;
      unh_ff   <= unh_in;
   end

   assign status.is_last  = last_ff;
   assign status.red_busy = red_busy;
   assign status.out_free = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_word  = hash_ff;
   assign rsp_unhashable = unh_ff;

endmodule

// ===== rtl/khash_ctrl.sv =====
module khash_ctrl
   import khash_pkg::*;
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   input  khash_status_type  status,
   output khash_cmd_type     cmd
   );

   khash_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == KIND_CHAR) ? ST_TERM_MUL : ST_EMIT;
            end
         end
         ST_TERM_MUL:  state_in = ST_TERM_ADD;
         ST_TERM_ADD:  state_in = ST_SUM_START;
         ST_SUM_START: state_in = ST_SUM_RED;
         ST_SUM_RED: begin
            if (!status.red_busy) begin
               state_in = ST_POW_MUL;
            end
         end
         ST_POW_MUL:   state_in = ST_POW_START;
         ST_POW_START: state_in = ST_POW_RED;
         ST_POW_RED: begin
            if (!status.red_busy) begin
               state_in = status.is_last ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_TERM_MUL:  cmd.term_mul  = 1'b1;
         ST_TERM_ADD:  cmd.term_add  = 1'b1;
         ST_SUM_START: cmd.sum_start = 1'b1;
         ST_SUM_RED:   cmd.sum_write = ~status.red_busy;
         ST_POW_MUL:   cmd.pow_mul   = 1'b1;
         ST_POW_START: cmd.pow_start = 1'b1;
         ST_POW_RED:   cmd.pow_write = ~status.red_busy;
         ST_EMIT:      cmd.emit      = status.out_free;
         default:      cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/key_polynomial_hash_core.sv =====
// channel   dir  transaction                          payload
// req_bus   in   one scalar word, char or container   key_kind, key_value, last
// rsp_bus   out  one hash per finished key            hash_word, unhashable
// csr_*     in   register write, no handshake         csr_index, csr_wdata
//
// scalar and container keys: idle, then emit, which waits for a free output
// string characters: sum and power each reduced by the shared restoring reducer
//   (one remainder bit per cycle, 40 steps for the sum, 60 for the power)
// last character goes on to the emit state to load the result register
// reset clears the controller, the registers to 31 and 1000000009, the key state
// a stalled result holds in its register while the next item is taken
module key_polynomial_hash_core
   import khash_pkg::*;
   (
   input  logic                 clock,
   input  logic                 reset,
   khash_req_if.sink            req_bus,
   khash_rsp_if.source          rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
   );

   // command and status between sequencer and datapath
   khash_cmd_type    cmd;
   khash_status_type status;

   // sequencer: accepts one item at a time and steps the multiply and reduce
   khash_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.key_kind),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: key state, shared multiplier, reducer, result register
   khash_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .key_kind       (req_bus.key_kind),
      .key_value      (req_bus.key_value),
      .key_last       (req_bus.last),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_hash_word  (rsp_bus.hash_word),
      .rsp_unhashable (rsp_bus.unhashable)
   );

endmodule

// ===== rtl/khash_checker.sv =====
module khash_checker
   import khash_pkg::*;
   (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [KIND_W-1:0] req_key_kind,
   input logic [WORD_W-1:0] req_key_value,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_hash_word,
   input logic              rsp_unhashable
   );

   logic req_fire;
   assign req_fire = req_valid & req_ready;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_word)
                                  && $stable(rsp_unhashable))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unhashable |-> rsp_hash_word == '0)
      else $error("unhashable result with nonzero hash");

   // a scalar key passes through the emit state to the result register when the output is free
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_key_kind == KIND_SCALAR && (!rsp_valid || rsp_ready)
      |-> ##2 (rsp_valid && !rsp_unhashable
               && rsp_hash_word == $past(req_key_value, 2)))
      else $error("scalar key not passed through");

   // a character occupies the reducer, no item right behind it
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_key_kind == KIND_CHAR |=> !req_ready)
      else $error("ready right after a character");

endmodule

bind key_polynomial_hash_core khash_checker u_khash_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_key_kind   (req_bus.key_kind),
   .req_key_value  (req_bus.key_value),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hash_word  (rsp_bus.hash_word),
   .rsp_unhashable (rsp_bus.unhashable)
);
